/* src/can_per_node_capture_rings_unit_macros.svh */
// ----------------------------------------------------------------------------
// capture rings assertion macros
// implication checks that compile away when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef CAN_PER_NODE_CAPTURE_RINGS_UNIT_MACROS_SVH
`define CAN_PER_NODE_CAPTURE_RINGS_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define CCR_ASSERT_IMPL(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("ccr: same-cycle check failed");

// next-cycle implication
`define CCR_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("ccr: next-cycle check failed");

`else

`define CCR_ASSERT_IMPL(lbl, clk, rst_n, a, c)
`define CCR_ASSERT_NEXT(lbl, clk, rst_n, a, c)

`endif

`endif

/* src/ccr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccr_pkg
// shared constants and controller/datapath interface types
// ----------------------------------------------------------------------------
package ccr_pkg;

  localparam int NODE_COUNT   = 128;
  localparam int NODE_W       = 7;
  localparam int GROUP_W      = 8;
  localparam int GROUP_COUNT  = NODE_COUNT / GROUP_W;
  localparam int GROUP_IDX_W  = 4;
  localparam int GROUP_SEL_W  = 3;
  localparam int PEND_CNT_W   = 8;

  localparam int ID_W         = 29;
  localparam int DLC_W        = 4;
  localparam int FRAME_W      = ID_W + DLC_W + 64;
  localparam int TDATA_W      = 104;

  localparam logic FUNC_FEED  = 1'b0;
  localparam logic FUNC_DRAIN = 1'b1;

  typedef struct packed {
    logic in_take;
    logic feed_wr;
    logic scan_start;
    logic scan_step;
    logic meta_rd_found;
    logic meta_latch;
    logic frame_rd;
    logic out_load;
    logic drain_done;
  } cmd_t;

  typedef struct packed {
    logic found;
    logic scan_end;
    logic any_pending;
    logic is_last;
    logic out_free;
  } sts_t;

endpackage

/* src/ccr_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccr_ctrl
// sequencer for feed and drain requests
// ----------------------------------------------------------------------------
module ccr_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_func,
  output logic          in_ready,
  input  ccr_pkg::sts_t sts,
  output ccr_pkg::cmd_t cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_FEED  = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_META  = 3'd3;
  localparam logic [2:0] ST_FRD   = 3'd4;
  localparam logic [2:0] ST_FLOAD = 3'd5;

  logic [2:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.in_take = 1'b1;
          if (in_func == ccr_pkg::FUNC_FEED) begin
            state_nxt = ST_FEED;
          end else if (sts.any_pending) begin
            cmd.scan_start = 1'b1;
            state_nxt      = ST_SCAN;
          end
        end
      end
      ST_FEED: begin
        cmd.feed_wr = 1'b1;
        state_nxt   = ST_IDLE;
      end
      ST_SCAN: begin
        priority if (sts.found) begin
          cmd.meta_rd_found = 1'b1;
          state_nxt         = ST_META;
        end else if (sts.scan_end) begin
          state_nxt = ST_IDLE;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      ST_META: begin
        cmd.meta_latch = 1'b1;
        state_nxt      = ST_FRD;
      end
      ST_FRD: begin
        cmd.frame_rd = 1'b1;
        state_nxt    = ST_FLOAD;
      end
      ST_FLOAD: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          if (sts.is_last) begin
            cmd.drain_done = 1'b1;
            state_nxt      = ST_IDLE;
          end else begin
            state_nxt = ST_FRD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

/* src/ccr_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccr_datapath
// frame store, per-node ring pointers, pending map and output register
// ----------------------------------------------------------------------------
module ccr_datapath #(
  parameter int RING_DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ccr_pkg::cmd_t               cmd,
  output ccr_pkg::sts_t               sts,
  input  logic [ccr_pkg::FRAME_W-1:0] in_data,
  output logic [ccr_pkg::FRAME_W-1:0] out_data,
  output logic                        out_last,
  output logic                        out_more,
  output logic                        out_valid,
  input  logic                        out_ready
);

  localparam int HEAD_W     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CNT_W      = $clog2(RING_DEPTH + 1);
  localparam int SUM_W      = CNT_W + 1;
  localparam int SLOT_COUNT = ccr_pkg::NODE_COUNT * RING_DEPTH;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);
  localparam int META_W     = HEAD_W + CNT_W;
  localparam logic [SUM_W-1:0]  DEPTH_S  = SUM_W'(RING_DEPTH);
  localparam logic [SLOT_W-1:0] DEPTH_SL = SLOT_W'(RING_DEPTH);

  function automatic logic [HEAD_W-1:0] wrap_pos(input logic [SUM_W-1:0] s);
    logic [SUM_W-1:0] r;
    r = (s >= DEPTH_S) ? (s - DEPTH_S) : s;
    return r[HEAD_W-1:0];
  endfunction

  function automatic logic [SLOT_W-1:0] slot_of(input logic [ccr_pkg::NODE_W-1:0] node,
                                                input logic [HEAD_W-1:0] pos);
    return SLOT_W'(node) * DEPTH_SL + SLOT_W'(pos);
  endfunction

  // storage
  logic [ccr_pkg::FRAME_W-1:0] frame_mem [SLOT_COUNT];
  logic [META_W-1:0]           meta_mem  [ccr_pkg::NODE_COUNT];

  logic [ccr_pkg::NODE_COUNT-1:0] pending_r, pending_nxt;
  logic [ccr_pkg::PEND_CNT_W-1:0] pend_cnt_r, pend_cnt_nxt;

  logic [ccr_pkg::FRAME_W-1:0]    in_data_r;
  logic [META_W-1:0]              meta_rdata_r;
  logic [ccr_pkg::FRAME_W-1:0]    frame_rdata_r;

  logic [ccr_pkg::GROUP_IDX_W-1:0] grp_r;
  logic [ccr_pkg::NODE_W-1:0]      drain_node_r;
  logic [HEAD_W-1:0]               head_r;
  logic [CNT_W-1:0]                cnt_r;
  logic [CNT_W-1:0]                k_r;
  logic                            more_r;

  logic [ccr_pkg::FRAME_W-1:0] out_data_r;
  logic                        out_last_r;
  logic                        out_more_r;
  logic                        out_valid_r;

  // feed path
  logic [ccr_pkg::NODE_W-1:0] in_node;
  logic [ccr_pkg::NODE_W-1:0] feed_node;
  logic                       was_pend;
  logic [HEAD_W-1:0]          cur_head, adj_head, wpos;
  logic [CNT_W-1:0]           cur_cnt, adj_cnt, new_cnt;

  // scan and drain path
  logic [ccr_pkg::GROUP_W-1:0]     grp_bits;
  logic [ccr_pkg::GROUP_SEL_W-1:0] enc;
  logic [ccr_pkg::NODE_W-1:0]      found_node;
  logic [ccr_pkg::NODE_W-1:0]      meta_raddr;
  logic                            meta_rd;
  logic [HEAD_W-1:0]               dpos;

  assign in_node   = in_data[ccr_pkg::NODE_W-1:0];
  assign feed_node = in_data_r[ccr_pkg::NODE_W-1:0];

  // a node without its pending bit reads as head and count zero
  always_comb begin
    was_pend = pending_r[feed_node];
    cur_head = was_pend ? meta_rdata_r[META_W-1:CNT_W] : '0;
    cur_cnt  = was_pend ? meta_rdata_r[CNT_W-1:0] : '0;
    if (SUM_W'(cur_cnt) >= DEPTH_S) begin
      // full ring: drop the oldest
      adj_head = wrap_pos(SUM_W'(cur_head) + SUM_W'(1));
      adj_cnt  = CNT_W'(RING_DEPTH - 1);
    end else begin
      adj_head = cur_head;
      adj_cnt  = cur_cnt;
    end
    wpos    = wrap_pos(SUM_W'(adj_head) + SUM_W'(adj_cnt));
    new_cnt = adj_cnt + CNT_W'(1);
  end

  always_comb begin
    grp_bits = pending_r[grp_r * ccr_pkg::GROUP_W +: ccr_pkg::GROUP_W];
    enc      = '0;
    for (int i = ccr_pkg::GROUP_W - 1; i >= 0; i--) begin
      if (grp_bits[i]) begin
        enc = ccr_pkg::GROUP_SEL_W'(i);
      end
    end
    found_node = {grp_r, enc};
  end

  assign meta_rd    = cmd.in_take | cmd.meta_rd_found;
  assign meta_raddr = cmd.meta_rd_found ? found_node : in_node;
  assign dpos       = wrap_pos(SUM_W'(head_r) + SUM_W'(k_r));

  // memories
  always_ff @(posedge clk) begin
    if (cmd.feed_wr) begin
      meta_mem[feed_node] <= {adj_head, new_cnt};
    end
    if (meta_rd) begin
      meta_rdata_r <= meta_mem[meta_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.feed_wr) begin
      frame_mem[slot_of(feed_node, wpos)] <= in_data_r;
    end
    if (cmd.frame_rd) begin
      frame_rdata_r <= frame_mem[slot_of(drain_node_r, dpos)];
    end
  end

  // pending map and pending node count
  always_comb begin
    pending_nxt  = pending_r;
    pend_cnt_nxt = pend_cnt_r;
    if (cmd.feed_wr) begin
      pending_nxt[feed_node] = 1'b1;
      if (!was_pend) begin
        pend_cnt_nxt = pend_cnt_r + ccr_pkg::PEND_CNT_W'(1);
      end
    end
    if (cmd.drain_done) begin
      pending_nxt[drain_node_r] = 1'b0;
      pend_cnt_nxt              = pend_cnt_r - ccr_pkg::PEND_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r   <= '0;
      pend_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pending_r  <= pending_nxt;
      pend_cnt_r <= pend_cnt_nxt;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.in_take) begin
      in_data_r <= in_data;
    end
    if (cmd.scan_start) begin
      grp_r <= '0;
    end else if (cmd.scan_step) begin
      grp_r <= grp_r + ccr_pkg::GROUP_IDX_W'(1);
    end
    if (cmd.meta_rd_found) begin
      drain_node_r <= found_node;
    end
    if (cmd.meta_latch) begin
      head_r <= meta_rdata_r[META_W-1:CNT_W];
      cnt_r  <= meta_rdata_r[CNT_W-1:0];
      k_r    <= '0;
      more_r <= (pend_cnt_r > ccr_pkg::PEND_CNT_W'(1));
    end else if (cmd.out_load) begin
      k_r <= k_r + CNT_W'(1);
    end
    if (cmd.out_load) begin
      out_data_r <= frame_rdata_r;
      out_last_r <= sts.is_last;
      out_more_r <= more_r;
    end
  end

  assign sts.found       = |grp_bits;
  assign sts.scan_end    = (grp_r == ccr_pkg::GROUP_IDX_W'(ccr_pkg::GROUP_COUNT - 1));
  assign sts.any_pending = (pend_cnt_r != '0);
  assign sts.is_last     = ((SUM_W'(k_r) + SUM_W'(1)) == SUM_W'(cnt_r));
  assign sts.out_free    = !out_valid_r || out_ready;

  assign out_data  = out_data_r;
  assign out_last  = out_last_r;
  assign out_more  = out_more_r;
  assign out_valid = out_valid_r;

endmodule

/* src/can_per_node_capture_rings_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_per_node_capture_rings_unit
// per-node ring store for captured can frames, drained one node at a time
// ----------------------------------------------------------------------------
// usage
//   input stream: one request per frame to feed (in_tuser = 0) or one drain
//   request (in_tuser = 1). a feed appends the frame to the ring of node
//   can_id[6:0], dropping that ring's oldest frame when it is full.
//   a drain empties the lowest-numbered node holding frames and sends its
//   frames oldest first on the output stream; out_tlast marks the final one
//   and out_tuser says whether another node still holds frames.
//   a drain with nothing stored sends nothing.
// sequence
//   feed: meta read, then ring update and frame write.
//   drain: accept, pending-map scan of up to 16 groups (8 nodes a cycle),
//   meta read, then per frame a frame store read and a load into the output
//   register, which waits while a stalled receiver holds that register.
// reset
//   rst_n clears the pending map and counters, so every ring is empty at
//   once; the frame store itself keeps no reset.
// stall
//   a stalled receiver holds the output register; the drain waits on it and
//   no new request is taken until the drain's last frame is loaded.
// ----------------------------------------------------------------------------
`include "can_per_node_capture_rings_unit_macros.svh"

module can_per_node_capture_rings_unit #(
  parameter int RING_DEPTH = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // request channel
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // can_id[28:0], dlc[32:29], byte0[40:33] .. byte7[96:89], zero pad
  input  logic [ccr_pkg::TDATA_W-1:0] in_tdata,
  // func[0]
  input  logic [0:0]                  in_tuser,
  // result channel
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // out_id[28:0], out_dlc[32:29], out_b0[40:33] .. out_b7[96:89], zero pad
  output logic [ccr_pkg::TDATA_W-1:0] out_tdata,
  output logic                        out_tlast,
  // more_pending[0]
  output logic [0:0]                  out_tuser
);

  ccr_pkg::cmd_t cmd;
  ccr_pkg::sts_t sts;

  logic [ccr_pkg::FRAME_W-1:0] out_frame;
  logic                        out_more;

  // sequencer
  ccr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_func  (in_tuser[0]),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // store, pointers and output register
  ccr_datapath #(
    .RING_DEPTH (RING_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_tdata[ccr_pkg::FRAME_W-1:0]),
    .out_data  (out_frame),
    .out_last  (out_tlast),
    .out_more  (out_more),
    .out_valid (out_tvalid),
    .out_ready (out_tready)
  );

  // zero pad up to whole bytes
  assign out_tdata = {{(ccr_pkg::TDATA_W - ccr_pkg::FRAME_W){1'b0}}, out_frame};
  assign out_tuser = out_more;

  // a feed request keeps the input closed for its write cycle
  `CCR_ASSERT_NEXT(a_feed_busy, clk, rst_n,
                   in_tvalid && in_tready && (in_tuser[0] == ccr_pkg::FUNC_FEED),
                   !in_tready)
  // a frame is never loaded over one the receiver has not taken
  `CCR_ASSERT_IMPL(a_load_free, clk, rst_n, cmd.out_load, !out_tvalid || out_tready)
  // a drain ends only on the load of its final frame
  `CCR_ASSERT_IMPL(a_done_last, clk, rst_n, cmd.drain_done, cmd.out_load && sts.is_last)
  // the last frame of a drain shows up with tlast in the next cycle
  `CCR_ASSERT_NEXT(a_tlast_out, clk, rst_n, cmd.drain_done, out_tvalid && out_tlast)

endmodule

/* test/can_per_node_capture_rings_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// can_per_node_capture_rings_unit_tb
// self-checking bench for the per-node can capture rings: feed and drain
// requests go in through a queued driver, a clocked monitor keeps a shadow
// copy of every node's ring and checks each drained frame field by field,
// with random idling on both sides and one long output stall
// ----------------------------------------------------------------------------
module can_per_node_capture_rings_unit_tb;

  localparam int RING_SLOTS   = 16;
  localparam int RANDOM_REQS  = 480;
  localparam int TAIL_REQS    = 60;   // last stretch of the run runs with no idling
  localparam int LONG_HOLD    = 300;  // cycles the receiver backs off once
  localparam int HOT_NODES    = 5;

  // one request as the driver sees it
  typedef struct packed {
    logic                      func;
    logic [ccr_pkg::ID_W-1:0]  can_id;
    logic [ccr_pkg::DLC_W-1:0] dlc;
    logic [63:0]               payload;   // byte0 in bits 7..0
  } capture_req_t;

  // one drained frame as it should leave the block
  typedef struct packed {
    logic [ccr_pkg::ID_W-1:0]  can_id;
    logic [ccr_pkg::DLC_W-1:0] dlc;
    logic [63:0]               payload;
    logic                      last;
    logic                      more_pending;
  } drained_frame_t;

  logic                        clk;
  logic                        rst_n = 1'b0;
  logic                        in_tvalid = 1'b0;
  logic                        in_tready;
  logic [ccr_pkg::TDATA_W-1:0] in_tdata = '0;
  logic [0:0]                  in_tuser = '0;
  logic                        out_tvalid;
  logic                        out_tready = 1'b0;
  logic [ccr_pkg::TDATA_W-1:0] out_tdata;
  logic                        out_tlast;
  logic [0:0]                  out_tuser;

  can_per_node_capture_rings_unit #(
    .RING_DEPTH(RING_SLOTS)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  // shadow of the capture store: {dlc, can_id, payload} per slot
  logic [ccr_pkg::DLC_W+ccr_pkg::ID_W+63:0] shadow_slot [ccr_pkg::NODE_COUNT][RING_SLOTS];
  int                     shadow_head [ccr_pkg::NODE_COUNT];
  int                     shadow_fill [ccr_pkg::NODE_COUNT];

  capture_req_t   pending_reqs [$];   // requests not yet put on the bus
  drained_frame_t frames_due   [$];   // frames the block still owes us

  int   fail_count   = 0;
  int   frames_seen  = 0;
  int   idle_left    = 0;
  int   hold_left    = 0;
  bit   long_hold_done = 0;
  logic tail_phase   = 1'b0;          // set once only the last requests remain
  logic rx_long_hold = 1'b0;          // receiver is in its long back-off

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // generous cap on run time
  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // prediction: apply one accepted request to the shadow rings and queue the
  // frames that a drain must produce
  // --------------------------------------------------------------------------
  function automatic void apply_capture_req(capture_req_t r);
    int node;
    int slot;
    int n;
    bit others;
    drained_frame_t f;
    if (r.func == ccr_pkg::FUNC_FEED) begin
      node = int'(r.can_id[ccr_pkg::NODE_W-1:0]);
      // full ring: drop its oldest frame before storing the new one
      if (shadow_fill[node] >= RING_SLOTS) begin
        shadow_head[node] = (shadow_head[node] + 1) % RING_SLOTS;
        shadow_fill[node] = RING_SLOTS - 1;
      end
      slot = (shadow_head[node] + shadow_fill[node]) % RING_SLOTS;
      shadow_slot[node][slot] = {r.dlc, r.can_id, r.payload};
      shadow_fill[node]++;
      return;
    end
    // drain: lowest-numbered node holding frames, nothing at all if none
    node = 0;
    while (node < ccr_pkg::NODE_COUNT && shadow_fill[node] == 0) node++;
    if (node == ccr_pkg::NODE_COUNT) return;
    others = 0;
    for (int k = node + 1; k < ccr_pkg::NODE_COUNT; k++)
      if (shadow_fill[k] != 0) others = 1;
    n = shadow_fill[node];
    for (int k = 0; k < n; k++) begin
      slot = (shadow_head[node] + k) % RING_SLOTS;
      {f.dlc, f.can_id, f.payload} = shadow_slot[node][slot];
      f.last         = (k == n - 1);
      f.more_pending = others;
      frames_due.push_back(f);
    end
    shadow_head[node] = 0;
    shadow_fill[node] = 0;
  endfunction

  // --------------------------------------------------------------------------
  // request driver: pops the next request, or idles at random, when the bus may change
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    capture_req_t r;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (idle_left != 0) begin
        idle_left--;
        in_tvalid <= 1'b0;
      end else if (pending_reqs.size() == 0) begin
        in_tvalid <= 1'b0;
      end else if (!tail_phase && !rx_long_hold && $urandom_range(0, 9) == 0) begin
        // idle burst that starts with this cycle
        idle_left = $urandom_range(1, 6) - 1;
        in_tvalid <= 1'b0;
      end else begin
        r = pending_reqs.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {7'b0, r.payload, r.dlc, r.can_id};
        in_tuser  <= r.func;
      end
    end
    tail_phase <= (pending_reqs.size() < TAIL_REQS);
  end

  // --------------------------------------------------------------------------
  // monitor: checks drained frames, predicts from accepted requests, and
  // throttles the output ready
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    drained_frame_t exp_f;
    capture_req_t   acc;
    logic [7:0]     got_b;
    logic [7:0]     exp_b;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      // check a frame leaving the block against the oldest expectation
      if (out_tvalid && out_tready) begin
        frames_seen++;
        if (frames_due.size() == 0) begin
          $error("unexpected drained frame id %0h", out_tdata[ccr_pkg::ID_W-1:0]);
          fail_count++;
        end else begin
          exp_f = frames_due.pop_front();
          if (out_tdata[ccr_pkg::ID_W-1:0] !== exp_f.can_id) begin
            $error("out_id expected %0h got %0h", exp_f.can_id,
                   out_tdata[ccr_pkg::ID_W-1:0]);
            fail_count++;
          end
          if (out_tdata[ccr_pkg::ID_W +: ccr_pkg::DLC_W] !== exp_f.dlc) begin
            $error("out_dlc expected %0h got %0h", exp_f.dlc,
                   out_tdata[ccr_pkg::ID_W +: ccr_pkg::DLC_W]);
            fail_count++;
          end
          for (int b = 0; b < 8; b++) begin
            got_b = out_tdata[ccr_pkg::ID_W + ccr_pkg::DLC_W + 8*b +: 8];
            exp_b = exp_f.payload[8*b +: 8];
            if (got_b !== exp_b) begin
              $error("out_b%0d expected %0h got %0h", b, exp_b, got_b);
              fail_count++;
            end
          end
          if (out_tlast !== exp_f.last) begin
            $error("last expected %0b got %0b", exp_f.last, out_tlast);
            fail_count++;
          end
          if (out_tuser[0] !== exp_f.more_pending) begin
            $error("more_pending expected %0b got %0b", exp_f.more_pending, out_tuser[0]);
            fail_count++;
          end
        end
      end
      // a request taken at this edge cannot show up before the next one
      if (in_tvalid && in_tready) begin
        acc.func    = in_tuser[0];
        acc.can_id  = in_tdata[ccr_pkg::ID_W-1:0];
        acc.dlc     = in_tdata[ccr_pkg::ID_W +: ccr_pkg::DLC_W];
        acc.payload = in_tdata[ccr_pkg::ID_W + ccr_pkg::DLC_W +: 64];
        apply_capture_req(acc);
      end
      // ready throttling, with one long back-off so the block fills and stalls
      if (hold_left != 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (!long_hold_done && frames_seen >= 40) begin
        long_hold_done = 1;
        hold_left = LONG_HOLD - 1;
        rx_long_hold <= 1'b1;
        out_tready <= 1'b0;
      end else if (!tail_phase && $urandom_range(0, 7) == 0) begin
        hold_left = $urandom_range(1, 6) - 1;
        out_tready <= 1'b0;
      end else begin
        rx_long_hold <= 1'b0;
        out_tready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus and end of run
  // --------------------------------------------------------------------------
  function automatic capture_req_t make_feed(logic [ccr_pkg::ID_W-1:0] id,
                                             logic [ccr_pkg::DLC_W-1:0] dlc,
                                             logic [63:0] payload);
    capture_req_t r;
    r.func    = ccr_pkg::FUNC_FEED;
    r.can_id  = id;
    r.dlc     = dlc;
    r.payload = payload;
    return r;
  endfunction

  function automatic capture_req_t make_random_req(logic func,
                                                   logic [ccr_pkg::NODE_W-1:0] node);
    capture_req_t r;
    r.func    = func;
    r.can_id  = ccr_pkg::ID_W'($urandom());
    r.can_id[ccr_pkg::NODE_W-1:0] = node;
    r.dlc     = ccr_pkg::DLC_W'($urandom_range(0, 15));
    r.payload = {$urandom(), $urandom()};
    return r;
  endfunction

  initial begin
    logic [ccr_pkg::NODE_W-1:0] hot [HOT_NODES];
    logic [ccr_pkg::NODE_W-1:0] node;
    capture_req_t               r;
    int                         roll;

    for (int n = 0; n < ccr_pkg::NODE_COUNT; n++) begin
      shadow_head[n] = 0;
      shadow_fill[n] = 0;
    end

    // directed: drain of an empty store, with every other field set
    r = make_feed('1, '1, '1);
    r.func = ccr_pkg::FUNC_DRAIN;
    pending_reqs.push_back(r);
    // field extremes on the lowest and highest node
    pending_reqs.push_back(make_feed('0, '0, '0));
    pending_reqs.push_back(make_feed('1, '1, '1));
    pending_reqs.push_back(make_feed(29'h1FFF_FF80, 4'hF, 64'h55AA_55AA_55AA_55AA));
    // drain node 0 with node 127 still waiting, then node 127 alone
    pending_reqs.push_back(make_random_req(ccr_pkg::FUNC_DRAIN, '0));
    pending_reqs.push_back(make_random_req(ccr_pkg::FUNC_DRAIN, '1));
    // one past a full ring on node 5 drops its oldest frame
    for (int i = 0; i <= RING_SLOTS; i++)
      pending_reqs.push_back(make_random_req(ccr_pkg::FUNC_FEED, 7'd5));
    pending_reqs.push_back(make_random_req(ccr_pkg::FUNC_FEED, 7'd9));
    pending_reqs.push_back(make_random_req(ccr_pkg::FUNC_DRAIN, '0));
    pending_reqs.push_back(make_random_req(ccr_pkg::FUNC_DRAIN, '0));

    // random: feeds crowd a few hot nodes so rings wrap and overflow,
    // drains come often enough to empty them regularly
    for (int i = 0; i < HOT_NODES; i++)
      hot[i] = ccr_pkg::NODE_W'($urandom_range(0, ccr_pkg::NODE_COUNT - 1));
    for (int i = 0; i < RANDOM_REQS; i++) begin
      roll = $urandom_range(0, 99);
      if ($urandom_range(0, 3) != 0) node = hot[$urandom_range(0, HOT_NODES - 1)];
      else node = ccr_pkg::NODE_W'($urandom_range(0, ccr_pkg::NODE_COUNT - 1));
      if (roll < 16) pending_reqs.push_back(make_random_req(ccr_pkg::FUNC_DRAIN, node));
      else pending_reqs.push_back(make_random_req(ccr_pkg::FUNC_FEED, node));
    end
    // flush what is left
    for (int i = 0; i < 12; i++)
      pending_reqs.push_back(make_random_req(ccr_pkg::FUNC_DRAIN,
                             ccr_pkg::NODE_W'($urandom_range(0, ccr_pkg::NODE_COUNT - 1))));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // all requests taken, then all frames back, then let a trailing scan settle
    while (pending_reqs.size() != 0 || in_tvalid) @(negedge clk);
    while (frames_due.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);

    if (frames_due.size() != 0) begin
      $error("%0d drained frames never arrived", frames_due.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
